FILE: sv/assert_macros.svh
// Assertion macros for the cam tooth group decoder RTL.
// Included by the top module, which carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/ctgpd_pkg.sv
// Package for the cam tooth group position decoder: widths, register codes,
// group patterns and the pattern lookup. No dependencies.
`timescale 1ns / 1ps

package ctgpd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_SEQUENTIAL_ENABLE   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_EIGHT_CYLINDER_MODE = 1'd1;

  localparam logic [TimeW-1:0] START_FILTER = 32'd392;

  localparam logic [PosW-1:0] GROUPS_SIX   = 4'd6;
  localparam logic [PosW-1:0] GROUPS_EIGHT = 4'd8;
  localparam int unsigned     GroupsMax    = 8;

  // Teeth per group. Entry 0 repeats the last group and the final entry
  // repeats group 1, so both neighbors of every group are at hand.
  localparam logic [1:0] PAT_SIX   [0:7] = '{2'd1, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd1, 2'd3};
  localparam logic [1:0] PAT_EIGHT [0:9] = '{2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd2, 2'd1,
                                             2'd3, 2'd1};

  // Expected tooth count at a pattern index; zero past the end of the table.
  function automatic logic [CountW-1:0] pat_at(input logic eight_mode,
                                               input logic [PosW-1:0] idx);
    logic [CountW-1:0] val;
    val = '0;
    if (eight_mode) begin
      if (idx < 4'd10) val = {6'd0, PAT_EIGHT[idx]};
    end else begin
      if (idx < 4'd8) val = {6'd0, PAT_SIX[idx[2:0]]};
    end
    return val;
  endfunction

endpackage

FILE: sv/ctgpd_intf.sv
// Valid/ready channel interfaces for cam edge requests and decoder results.
// Depends on ctgpd_pkg for field widths.
`timescale 1ns / 1ps

interface ctgpd_edge_if;
  import ctgpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [TimeW-1:0] edge_time;
  logic [TimeW-1:0] crank_last_time;
  logic [TimeW-1:0] crank_prev_time;

  modport source (output valid, edge_time, crank_last_time, crank_prev_time, input ready);
  modport sink   (input valid, edge_time, crank_last_time, crank_prev_time, output ready);
endinterface

interface ctgpd_result_if;
  import ctgpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [PosW-1:0]   group_position;
  logic [CountW-1:0] tooth_in_group;
  logic              edge_accepted;

  modport source (output valid, group_position, tooth_in_group, edge_accepted, input ready);
  modport sink   (input valid, group_position, tooth_in_group, edge_accepted, output ready);
endinterface

FILE: sv/cam_tooth_group_position_decoder_top.sv
// Cam tooth group position decoder, top level and only module.
// Depends on ctgpd_pkg, ctgpd_intf.sv and assert_macros.svh.
`timescale 1ns / 1ps

// Each request on cam_edge_i is one cam tooth falling edge with its timestamp and the two
// latest crank tooth timestamps. The block filters the edge against a noise window, detects
// group boundaries (a gap of at least three crank periods), matches the finished group against
// the six- or eight-group tooth pattern, and returns one result per request: the group
// position (0 = no cam sync), the tooth count in the current group, and whether the edge was
// accepted. Requests are first captured in an input register; once the output register is free,
// the decode and the state update happen together and the result lands in the output register.
// A request is thus taken every cycle while results drain. The throughput of one request per
// cycle while results drain is set by the state update, where each edge reads the timestamp,
// filter and counts left by the edge before it. The configuration port takes sequential_enable
// (index 0) and eight_cylinder_mode (index 1) and must be written only while no request is in
// flight.
module cam_tooth_group_position_decoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ctgpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ctgpd_pkg::CfgDataW-1:0] cfg_wdata_i,
  ctgpd_edge_if.sink                     cam_edge_i,
  ctgpd_result_if.source                 result_o
);
  import ctgpd_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers.
  logic seq_enable_q;
  logic eight_mode_q;

  // Input register.
  logic             in_valid_q;
  logic [TimeW-1:0] edge_time_q;
  logic [TimeW-1:0] crank_last_q;
  logic [TimeW-1:0] crank_prev_q;

  // Decoder state.
  logic [TimeW-1:0]  last_cam_q, last_cam_d;
  logic [TimeW-1:0]  filter_q, filter_d;
  logic [CountW-1:0] cur_count_q, cur_count_d;
  logic [CountW-1:0] prev_count_q, prev_count_d;
  logic [PosW-1:0]   sync_pos_q, sync_pos_d;

  // Output register.
  logic              out_valid_q;
  logic [PosW-1:0]   out_pos_q;
  logic [CountW-1:0] out_count_q;
  logic              out_accepted_q;

  logic out_free;
  logic advance;
  logic in_ready;

  // The input register moves into the output register whenever the output
  // register is empty or being drained in this cycle.
  assign out_free = !out_valid_q || result_o.ready;
  assign advance  = in_valid_q && out_free;
  assign in_ready = !in_valid_q || advance;

  assign cam_edge_i.ready = in_ready;

  // Decode of the registered edge against the current state.
  logic [TimeW-1:0]   gap;
  logic [TimeW-1:0]   crank_period;
  logic [TimeW+1:0]   threshold;
  logic               passed;
  logic               history_ok;
  logic               boundary;
  logic               normal_tooth;
  logic [PosW-1:0]    groups;
  logic [PosW-1:0]    pos_plus;
  logic               held_match;
  logic [PosW-1:0]    search_pos;
  logic [PosW-1:0]    boundary_pos;

  assign gap          = edge_time_q - last_cam_q;
  assign crank_period = crank_last_q - crank_prev_q;
  assign threshold    = {2'b00, crank_period} + {1'b0, crank_period, 1'b0};
  assign passed       = seq_enable_q && (gap > filter_q);
  assign history_ok   = (last_cam_q != '0) && (crank_last_q != '0) && (crank_prev_q != '0);
  assign boundary     = passed && history_ok && ({2'b00, gap} >= threshold);
  assign normal_tooth = passed && history_ok && !boundary && (cur_count_q != '0);

  assign groups   = eight_mode_q ? GROUPS_EIGHT : GROUPS_SIX;
  assign pos_plus = sync_pos_q + 4'd1;

  // The held position still predicts the group just finished.
  assign held_match = (sync_pos_q != '0) && (sync_pos_q <= groups) &&
                      (cur_count_q == pat_at(eight_mode_q, pos_plus));

  // Search for the lowest group whose count and predecessor count both match.
  always_comb begin
    search_pos = '0;
    for (int g = GroupsMax; g >= 1; g--) begin
      if ((PosW'(g) <= groups) &&
          (cur_count_q == pat_at(eight_mode_q, PosW'(g))) &&
          (prev_count_q == pat_at(eight_mode_q, PosW'(g - 1)))) begin
        search_pos = PosW'(g);
      end
    end
  end

  always_comb begin
    boundary_pos = sync_pos_q;
    if ((cur_count_q != '0) && (prev_count_q != '0)) begin
      if (held_match) begin
        boundary_pos = (pos_plus > groups) ? 4'd1 : pos_plus;
      end else begin
        boundary_pos = search_pos;
      end
    end
  end

  always_comb begin
    last_cam_d   = last_cam_q;
    filter_d     = filter_q;
    cur_count_d  = cur_count_q;
    prev_count_d = prev_count_q;
    sync_pos_d   = sync_pos_q;
    if (passed) begin
      last_cam_d = edge_time_q;
    end
    if (boundary) begin
      prev_count_d = cur_count_q;
      cur_count_d  = 8'd1;
      filter_d     = '0;
      sync_pos_d   = boundary_pos;
    end else if (normal_tooth) begin
      if (cur_count_q != 8'd255) begin
        cur_count_d = cur_count_q + 8'd1;
      end
      filter_d = gap >> 2;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_enable_q <= 1'b0;
      eight_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SEQUENTIAL_ENABLE:   seq_enable_q <= cfg_wdata_i[0];
        CFG_EIGHT_CYLINDER_MODE: eight_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input register: control is reset, payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= cam_edge_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && cam_edge_i.valid) begin
      edge_time_q  <= cam_edge_i.edge_time;
      crank_last_q <= cam_edge_i.crank_last_time;
      crank_prev_q <= cam_edge_i.crank_prev_time;
    end
  end

  // Decoder state, updated once per edge as it moves to the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cam_q   <= '0;
      filter_q     <= START_FILTER;
      cur_count_q  <= '0;
      prev_count_q <= '0;
      sync_pos_q   <= '0;
    end else if (advance) begin
      last_cam_q   <= last_cam_d;
      filter_q     <= filter_d;
      cur_count_q  <= cur_count_d;
      prev_count_q <= prev_count_d;
      sync_pos_q   <= sync_pos_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pos_q      <= sync_pos_d;
      out_count_q    <= cur_count_d;
      out_accepted_q <= passed;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.group_position = out_pos_q;
  assign result_o.tooth_in_group = out_count_q;
  assign result_o.edge_accepted  = out_accepted_q;

  // The position never leaves the range of the larger pattern.
  `ASSERT_IMPL(a_pos_range, clk_i, rst_ni, 1'b1, sync_pos_q <= GROUPS_EIGHT)
  // A group boundary opens the new group with one tooth and an open filter.
  `ASSERT_NEXT(a_boundary_restart, clk_i, rst_ni, advance && boundary,
               (cur_count_q == 8'd1) && (filter_q == '0))
  // A disabled edge leaves the timing state alone.
  `ASSERT_NEXT(a_disabled_holds, clk_i, rst_ni, advance && !seq_enable_q,
               $stable(last_cam_q) && $stable(filter_q) && $stable(cur_count_q))
  // Every result reports whether the edge it was produced from was accepted.
  `ASSERT_NEXT(a_accept_flag, clk_i, rst_ni, advance, out_valid_q && (out_accepted_q == $past(passed)))

endmodule
